### hw/rtl/llfl_pkg.sv
// ----------------------------------------------------------------------------
// llfl_pkg
// Shared constants, types and helpers for the linked list with free list.
// ----------------------------------------------------------------------------
package llfl_pkg;

  localparam int ENTRIES  = 12;
  localparam int KEY_BITS = 16;

  localparam int ACTION_W    = 2;
  localparam int PHOTO_KEY_W = 16;
  localparam int RATING_W    = 3;
  localparam int STATUS_W    = 3;

  localparam int LINK_W = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = LINK_W;
  localparam int DATA_W = KEY_BITS + RATING_W;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIST_ENTRY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIST_EMPTY = 3'd4;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_FREE,
    S_INS_WALK,
    S_INS_FIN,
    S_REM_CHK,
    S_REM_FIN,
    S_LIST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              link_we;
    logic [IDX_W-1:0]  link_addr;
    logic [LINK_W-1:0] link_wdata;
    logic              data_we;
    logic [IDX_W-1:0]  data_addr;
    logic [DATA_W-1:0] data_wdata;
  } mem_req_t;

  function automatic logic is_link(input logic [LINK_W-1:0] l);
    return l < LINK_W'(ENTRIES);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] l);
    return l[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/llfl_if.sv
// ----------------------------------------------------------------------------
// llfl_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface llfl_in_if;
  import llfl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [PHOTO_KEY_W-1:0] photo_key;
  logic [RATING_W-1:0]    star_rating;

  modport source (output valid, output action, output photo_key, output star_rating,
                  input ready);
  modport sink (input valid, input action, input photo_key, input star_rating,
                output ready);
endinterface

interface llfl_out_if;
  import llfl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [PHOTO_KEY_W-1:0] entry_key;
  logic [RATING_W-1:0]    entry_rating;
  logic                   last_result;

  modport source (output valid, output status, output entry_key, output entry_rating,
                  output last_result, input ready);
  modport sink (input valid, input status, input entry_key, input entry_rating,
                input last_result, output ready);
endinterface

### hw/rtl/llfl_ram.sv
// ----------------------------------------------------------------------------
// llfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/llfl_ctrl.sv
// ----------------------------------------------------------------------------
// llfl_ctrl
// Sequencer for insert, remove and list walks plus the result register.
// ----------------------------------------------------------------------------
module llfl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  llfl_in_if.sink                     in_ch,
  llfl_out_if.source                  out_ch,
  output llfl_pkg::mem_req_t          mem_req,
  input  logic [llfl_pkg::LINK_W-1:0] link_q,
  input  logic [llfl_pkg::DATA_W-1:0] data_q
);
  import llfl_pkg::*;

  state_t                 state_r, state_nxt;
  logic [LINK_W-1:0]      list_head_r, list_head_nxt;
  logic [LINK_W-1:0]      free_head_r, free_head_nxt;
  logic [LINK_W-1:0]      pos_r, pos_nxt;
  logic [LINK_W-1:0]      prev_r, prev_nxt;
  logic [LINK_W-1:0]      fresh_r, fresh_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [RATING_W-1:0]    rating_r, rating_nxt;
  logic [STATUS_W-1:0]    pend_r, pend_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [PHOTO_KEY_W-1:0] out_key_r, out_key_nxt;
  logic [RATING_W-1:0]    out_rating_r, out_rating_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   slot_free;
  logic                   link_ok;
  logic                   cnt_last;
  logic [KEY_BITS-1:0]    key_q;
  logic [RATING_W-1:0]    rating_q;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign link_ok     = is_link(link_q);
  assign cnt_last    = (cnt_r == CNT_W'(ENTRIES - 1));
  assign key_q       = data_q[DATA_W-1:RATING_W];
  assign rating_q    = data_q[RATING_W-1:0];

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_key    = out_key_r;
  assign out_ch.entry_rating = out_rating_r;
  assign out_ch.last_result  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      list_head_r <= LINK_NONE;
      free_head_r <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    prev_r       <= prev_nxt;
    fresh_r      <= fresh_nxt;
    key_r        <= key_nxt;
    rating_r     <= rating_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_rating_r <= out_rating_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    fresh_nxt      = fresh_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    rating_nxt     = rating_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_rating_nxt = out_rating_r;
    out_last_nxt   = out_last_r;
    mem_req         = '0;
    mem_req.rd_addr = to_idx(pos_r);

    unique case (state_r)
      S_INIT: begin
        // clearing pass: chain every entry onto the free list
        mem_req.link_we   = 1'b1;
        mem_req.link_addr = cnt_r[IDX_W-1:0];
        if (cnt_last) begin
          mem_req.link_wdata = LINK_NONE;
          cnt_nxt            = '0;
          state_nxt          = S_IDLE;
        end else begin
          mem_req.link_wdata = cnt_r + CNT_W'(1);
          cnt_nxt            = cnt_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt    = KEY_BITS'(in_ch.photo_key);
          rating_nxt = in_ch.star_rating;
          cnt_nxt    = '0;
          prev_nxt   = LINK_NONE;
          case (in_ch.action)
            ACT_INSERT: begin
              if (!is_link(free_head_r)) begin
                pend_nxt  = ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                fresh_nxt       = free_head_r;
                mem_req.rd_addr = to_idx(free_head_r);
                state_nxt       = S_INS_FREE;
              end
            end
            ACT_REMOVE: begin
              if (!is_link(list_head_r)) begin
                pend_nxt  = ST_NOT_FOUND;
                state_nxt = S_EMIT;
              end else begin
                pos_nxt         = list_head_r;
                mem_req.rd_addr = to_idx(list_head_r);
                state_nxt       = S_REM_CHK;
              end
            end
            ACT_LIST: begin
              if (!is_link(list_head_r)) begin
                pend_nxt  = ST_LIST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                pos_nxt         = list_head_r;
                mem_req.rd_addr = to_idx(list_head_r);
                state_nxt       = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_FREE: begin
        free_head_nxt = link_q;
        if (!is_link(list_head_r)) begin
          list_head_nxt = fresh_r;
          state_nxt     = S_INS_FIN;
        end else begin
          pos_nxt         = list_head_r;
          mem_req.rd_addr = to_idx(list_head_r);
          state_nxt       = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (!link_ok || cnt_last) begin
          // tail found: append the fresh entry
          mem_req.link_we    = 1'b1;
          mem_req.link_addr  = to_idx(pos_r);
          mem_req.link_wdata = fresh_r;
          state_nxt          = S_INS_FIN;
        end else begin
          pos_nxt         = link_q;
          cnt_nxt         = cnt_r + CNT_W'(1);
          mem_req.rd_addr = to_idx(link_q);
        end
      end
      S_INS_FIN: begin
        mem_req.link_we    = 1'b1;
        mem_req.link_addr  = to_idx(fresh_r);
        mem_req.link_wdata = LINK_NONE;
        mem_req.data_we    = 1'b1;
        mem_req.data_addr  = to_idx(fresh_r);
        mem_req.data_wdata = {key_r, rating_r};
        pend_nxt           = ST_DONE;
        state_nxt          = S_EMIT;
      end
      S_REM_CHK: begin
        if (key_q == key_r) begin
          // unlink the match
          if (is_link(prev_r)) begin
            mem_req.link_we    = 1'b1;
            mem_req.link_addr  = to_idx(prev_r);
            mem_req.link_wdata = link_q;
          end else begin
            list_head_nxt = link_q;
          end
          state_nxt = S_REM_FIN;
        end else if (!link_ok || cnt_last) begin
          pend_nxt  = ST_NOT_FOUND;
          state_nxt = S_EMIT;
        end else begin
          prev_nxt        = pos_r;
          pos_nxt         = link_q;
          cnt_nxt         = cnt_r + CNT_W'(1);
          mem_req.rd_addr = to_idx(link_q);
        end
      end
      S_REM_FIN: begin
        mem_req.link_we    = 1'b1;
        mem_req.link_addr  = to_idx(pos_r);
        mem_req.link_wdata = free_head_r;
        free_head_nxt      = pos_r;
        pend_nxt           = ST_DONE;
        state_nxt          = S_EMIT;
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_LIST_ENTRY;
          out_key_nxt    = PHOTO_KEY_W'(key_q);
          out_rating_nxt = rating_q;
          out_last_nxt   = !link_ok || cnt_last;
          if (!link_ok || cnt_last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt         = link_q;
            cnt_nxt         = cnt_r + CNT_W'(1);
            mem_req.rd_addr = to_idx(link_q);
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_r;
          out_key_nxt    = '0;
          out_rating_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_heads_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    is_link(list_head_r) && is_link(free_head_r) |-> list_head_r != free_head_r)
    else $error("list head and free head point at the same entry");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(ENTRIES))
    else $error("walk counter beyond pool size");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_LIST_ENTRY |-> out_last_r)
    else $error("non-list result without last flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.action == ACT_INSERT || in_ch.action == ACT_REMOVE ||
               in_ch.action == ACT_LIST) |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

### hw/rtl/linked_list_with_free_list.sv
// ----------------------------------------------------------------------------
// linked_list_with_free_list
// Pool of records kept as an ordered linked list plus a free list.
// ----------------------------------------------------------------------------
// After reset the block chains the pool onto the free list and accepts no
// request until that pass is done. Requests are then taken one at a time. The
// links live in one RAM and the key/rating pairs in another, both read once
// per cycle, so every walk advances one entry per cycle, the list walk only
// while the result slot is free. An insert takes the free head, walks to the
// tail and appends the fresh entry; a remove walks to the first match, unlinks
// it and returns it to the free list, or answers not found at the tail; a list
// presents one result per record, one per cycle, slower only when the result
// side holds off. A full pool or an empty list answers without a walk. The
// longest case is an insert behind eleven records, and the next request can be
// taken in the same cycle as the result is presented. A result register sits
// on the output, so a finished result may wait there while the next request is
// accepted.
// ----------------------------------------------------------------------------
module linked_list_with_free_list (
  input logic         clk,
  input logic         rst_n,
  llfl_in_if.sink     in_ch,
  llfl_out_if.source  out_ch
);
  import llfl_pkg::*;

  mem_req_t          mem_req;
  logic [LINK_W-1:0] link_q;
  logic [DATA_W-1:0] data_q;

  llfl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .link_q  (link_q),
    .data_q  (data_q)
  );

  llfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_req.link_we),
    .waddr (mem_req.link_addr),
    .wdata (mem_req.link_wdata),
    .raddr (mem_req.rd_addr),
    .rdata (link_q)
  );

  llfl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (mem_req.data_we),
    .waddr (mem_req.data_addr),
    .wdata (mem_req.data_wdata),
    .raddr (mem_req.rd_addr),
    .rdata (data_q)
  );

endmodule
